// ===== src/bounding_box_normalize_assert.svh =====
// Assertion macros used by the checker file of the normalizer.
// Each macro samples on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef BOUNDING_BOX_NORMALIZE_ASSERT_SVH
`define BOUNDING_BOX_NORMALIZE_ASSERT_SVH

// Same-cycle implication.
`define BBN_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BBN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bbn_pkg.sv =====
package bbn_pkg;

    // Default arithmetic format of the coordinates.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed widths of the stream fields.
    localparam int FIELD_WIDTH    = 32;
    localparam int OUT_WIDTH      = 16;
    localparam int AXES           = 3;
    localparam int IN_DATA_WIDTH  = AXES * FIELD_WIDTH;
    localparam int OUT_DATA_WIDTH = AXES * OUT_WIDTH;
    localparam int IN_USER_WIDTH  = 2;
    localparam int STATUS_WIDTH   = 2;

    // Bit positions inside the input tuser.
    localparam int USER_ACTION = 0;
    localparam int USER_FIRST  = 1;

    // Action codes.
    localparam logic ACT_MEASURE   = 1'b0;
    localparam logic ACT_NORMALIZE = 1'b1;

    typedef logic [STATUS_WIDTH-1:0] t_status;

    // Result status codes.
    localparam t_status STATUS_OK          = 2'd0;
    localparam t_status STATUS_ZERO_EXTENT = 2'd1;
    localparam t_status STATUS_EMPTY       = 2'd2;

endpackage

// ===== src/bbn_div.sv =====
// Restoring divider that forms floor(2^(QW-1) / divisor), one quotient bit a cycle.
module bbn_div #(
    parameter int DW = bbn_pkg::COORD_WIDTH_DEF,
    parameter int QW = 2 * bbn_pkg::FRAC_BITS_DEF + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [QW-1:0] o_quotient
);

    localparam int CNTW = $clog2(QW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_div;
    logic [QW-1:0]   r_quo;

    logic            w_lead;
    logic [DW:0]     w_trial;
    logic [DW:0]     w_diff;
    logic            w_fit;
    logic [DW-1:0]   n_rem;
    logic [QW-1:0]   n_quo;

    // The dividend is a single one in its top bit, so only the first step brings in a one.
    always_comb begin
        w_lead  = (r_cnt == '0);
        w_trial = {r_rem, w_lead};
        w_diff  = w_trial - {1'b0, r_div};
        w_fit   = (w_trial >= {1'b0, r_div});
        n_rem   = w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
        n_quo   = {r_quo[QW-2:0], w_fit};
    end

    // Step sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (r_cnt == CNTW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/bounding_box_normalize.sv =====
// Bounding-box normalizer for a vertex stream.
// Input stream (i_s_*): each request carries one vertex. tuser bit 0 is the action
// (0 measure, 1 normalize) and bit 1 marks the first vertex of a mesh in the measure pass.
// Output stream (o_m_*): one result per normalize request, three Q0.16 coordinates
// in tdata and a status code in tuser (0 ok, 1 zero extent, 2 nothing measured).
// A measure request produces no result and leaves the input ready for the next request.
// A normalize request holds the input from the accept cycle through one S_MUL step per
// axis on the shared multiplier, the S_SAT saturation step and the S_FIN load of the
// output register, after which its result is valid.
// A normalize request with an error status skips the multiplier and goes straight to S_FIN,
// or through S_SCALE first when the zero extent is found while the scale is computed.
// The first normalize request after measuring also computes the center and the
// reciprocal of the largest extent in S_SCALE, then waits in S_DIV for the serial divider.
// The result sits in an output register; measure requests are still taken while it
// waits. A normalize request that finishes while the receiver stalls waits until
// the register is free.
// Reset empties the bounds, drops the scale and clears the output valid.
module bounding_box_normalize #(
    parameter int COORD_WIDTH = bbn_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = bbn_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // coord_x [31:0], coord_y [63:32], coord_z [95:64]
    input  logic [bbn_pkg::IN_DATA_WIDTH-1:0]   i_s_tdata,
    // action [0], first [1]
    input  logic [bbn_pkg::IN_USER_WIDTH-1:0]   i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // norm_x [15:0], norm_y [31:16], norm_z [47:32]
    output logic [bbn_pkg::OUT_DATA_WIDTH-1:0]  o_m_tdata,
    // status [1:0]
    output logic [bbn_pkg::STATUS_WIDTH-1:0]    o_m_tuser
);

    localparam int CW       = COORD_WIDTH;
    localparam int QW       = 2 * FRAC_BITS + 1;
    localparam int MW       = CW + 1;
    localparam int PW       = MW + QW;
    localparam int OW       = bbn_pkg::OUT_WIDTH;
    localparam int FW       = bbn_pkg::FIELD_WIDTH;
    localparam int NAX      = bbn_pkg::AXES;
    localparam int SAT_POS  = 2 ** (OW - 1) - 1;
    localparam int SAT_NEG  = 2 ** (OW - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_DIV,
        S_MUL,
        S_SAT,
        S_FIN
    } t_state;

    t_state                   r_state;
    logic                     r_bvalid;
    logic                     r_sready;
    logic signed [CW-1:0]     r_low    [NAX];
    logic signed [CW-1:0]     r_high   [NAX];
    logic signed [CW-1:0]     r_center [NAX];
    logic signed [CW-1:0]     r_coord  [NAX];
    logic [CW-1:0]            r_ext;
    logic [QW-1:0]            r_inv;
    logic [1:0]               r_axis;
    logic [PW-1:0]            r_prod;
    logic                     r_neg;
    logic [OW-1:0]            r_norm   [NAX];
    bbn_pkg::t_status         r_status;
    logic                     r_ovalid;
    logic [bbn_pkg::OUT_DATA_WIDTH-1:0] r_odata;
    bbn_pkg::t_status         r_ostatus;

    logic [FW-1:0]            w_field  [NAX];
    logic [2*FW-1:0]          w_wide   [NAX];
    logic signed [CW-1:0]     w_coord  [NAX];
    logic [CW-1:0]            w_span   [NAX];
    logic signed [CW-1:0]     n_center [NAX];
    logic [CW-1:0]            n_ext;
    logic signed [MW-1:0]     w_diff;
    logic [MW-1:0]            w_mag;
    logic                     w_neg;
    logic [PW-1:0]            n_prod;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [QW-1:0]            w_quot;

    // Saturate a scaled magnitude to signed Q0.16; negative values round toward minus infinity.
    function automatic logic [OW-1:0] f_sat(input logic [PW-1:0] p, input logic neg);
        logic [PW-1:0] q;
        logic [OW-1:0] res;
        q = p >> FRAC_BITS;
        if (neg) begin
            if (|p[FRAC_BITS-1:0]) begin
                q = q + PW'(1);
            end
            if (q >= PW'(SAT_NEG)) begin
                res = OW'(SAT_NEG);
            end else begin
                res = OW'(0) - q[OW-1:0];
            end
        end else if (q > PW'(SAT_POS)) begin
            res = OW'(SAT_POS);
        end else begin
            res = q[OW-1:0];
        end
        return res;
    endfunction

    // Take each coordinate from the low COORD_WIDTH bits of its zero-extended field.
    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            w_field[a] = i_s_tdata[a*FW +: FW];
            w_wide[a]  = {{FW{1'b0}}, w_field[a]};
            w_coord[a] = w_wide[a][CW-1:0];
        end
    end

    // Center per axis and the largest extent.
    always_comb begin
        n_ext = '0;
        for (int a = 0; a < NAX; a++) begin
            w_span[a]   = r_high[a] - r_low[a];
            n_center[a] = r_low[a] + (w_span[a] >> 1);
            if (w_span[a] > n_ext) begin
                n_ext = w_span[a];
            end
        end
    end

    // Offset from the center and its product with the reciprocal, one axis a cycle.
    always_comb begin
        w_diff = {r_coord[r_axis][CW-1], r_coord[r_axis]}
               - {r_center[r_axis][CW-1], r_center[r_axis]};
        w_neg  = w_diff[MW-1];
        w_mag  = w_neg ? MW'(-w_diff) : w_diff;
        n_prod = PW'(w_mag) * PW'(r_inv);
    end

    assign w_div_start = (r_state == S_SCALE) && (n_ext != '0);

    bbn_div #(
        .DW(CW),
        .QW(QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_divisor  (n_ext),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Sequencer, bounds, scale and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bvalid <= 1'b0;
            r_sready <= 1'b0;
            r_ovalid <= 1'b0;
            r_axis   <= '0;
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        if (i_s_tuser[bbn_pkg::USER_ACTION] == bbn_pkg::ACT_MEASURE) begin
                            for (int a = 0; a < NAX; a++) begin
                                if (i_s_tuser[bbn_pkg::USER_FIRST] || !r_bvalid) begin
                                    r_low[a]  <= w_coord[a];
                                    r_high[a] <= w_coord[a];
                                end else begin
                                    if (w_coord[a] < r_low[a]) begin
                                        r_low[a] <= w_coord[a];
                                    end
                                    if (w_coord[a] > r_high[a]) begin
                                        r_high[a] <= w_coord[a];
                                    end
                                end
                            end
                            r_bvalid <= 1'b1;
                            r_sready <= 1'b0;
                        end else begin
                            r_coord <= w_coord;
                            r_axis  <= '0;
                            for (int a = 0; a < NAX; a++) begin
                                r_norm[a] <= '0;
                            end
                            if (!r_bvalid) begin
                                r_status <= bbn_pkg::STATUS_EMPTY;
                                r_state  <= S_FIN;
                            end else if (!r_sready) begin
                                r_state <= S_SCALE;
                            end else if (r_ext == '0) begin
                                r_status <= bbn_pkg::STATUS_ZERO_EXTENT;
                                r_state  <= S_FIN;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end
                    end
                end
                S_SCALE: begin
                    r_center <= n_center;
                    r_ext    <= n_ext;
                    if (n_ext == '0) begin
                        r_inv    <= '0;
                        r_sready <= 1'b1;
                        r_status <= bbn_pkg::STATUS_ZERO_EXTENT;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_inv    <= w_quot;
                        r_sready <= 1'b1;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= n_prod;
                    r_neg  <= w_neg;
                    // Saturate the product of the previous axis while this one multiplies.
                    if (r_axis != 2'd0) begin
                        r_norm[r_axis - 2'd1] <= f_sat(r_prod, r_neg);
                    end
                    if (r_axis == 2'd2) begin
                        r_state <= S_SAT;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                S_SAT: begin
                    r_norm[2] <= f_sat(r_prod, r_neg);
                    r_status  <= bbn_pkg::STATUS_OK;
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid  <= 1'b1;
                        r_odata   <= {r_norm[2], r_norm[1], r_norm[0]};
                        r_ostatus <= r_status;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ostatus;

endmodule

// ===== src/bbn_chk.sv =====
`include "bounding_box_normalize_assert.svh"

// Port-level checks of the normalizer.
module bbn_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               i_s_tready,
    input logic [bbn_pkg::IN_USER_WIDTH-1:0]  i_s_tuser,
    input logic                               i_m_tvalid,
    input logic                               i_m_tready,
    input logic [bbn_pkg::OUT_DATA_WIDTH-1:0] i_m_tdata,
    input logic [bbn_pkg::STATUS_WIDTH-1:0]   i_m_tuser
);

    // A result that is not ok carries zero coordinates.
    `BBN_ASSERT_IMPL(a_err_zero, i_m_tvalid && (i_m_tuser != bbn_pkg::STATUS_OK), i_m_tdata == '0, "error result with nonzero data")

    // The status code stays within the defined codes.
    `BBN_ASSERT_IMPL(a_status_code, i_m_tvalid, (i_m_tuser == bbn_pkg::STATUS_OK) || (i_m_tuser == bbn_pkg::STATUS_ZERO_EXTENT) || (i_m_tuser == bbn_pkg::STATUS_EMPTY), "undefined status code")

    // A normalize request keeps the input closed in the next cycle.
    `BBN_ASSERT_NEXT(a_norm_busy, i_s_tvalid && i_s_tready && (i_s_tuser[bbn_pkg::USER_ACTION] == bbn_pkg::ACT_NORMALIZE), !i_s_tready, "input open after a normalize request")

    // A measure request leaves the input open in the next cycle.
    `BBN_ASSERT_NEXT(a_meas_fast, i_s_tvalid && i_s_tready && (i_s_tuser[bbn_pkg::USER_ACTION] == bbn_pkg::ACT_MEASURE), i_s_tready, "input closed after a measure request")

    // A stalled result holds.
    `BBN_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "stalled result changed")

endmodule

bind bounding_box_normalize bbn_chk u_bbn_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
